[src/ssh_pkg.sv]
package ssh_pkg;

    localparam int NUM_LAYERS    = 4;
    localparam int CORDIC_STAGES = 16;
    localparam int STG_W         = 5;
    localparam int CW            = 32;
    localparam int DIV_W         = 51;
    localparam int MODNUM_W      = 18;
    localparam int MOD_STEPS     = MODNUM_W;
    localparam int LX_W          = 19;
    localparam int LX_SHIFT      = 31;
    localparam int GEO_W         = 64;
    localparam int CFG_IDX_W     = 3;

    localparam logic signed [CW-1:0] PI_Q28     = 32'sd843314857;
    localparam logic [30:0]          TWO_PI_Q28 = 31'd1686629713;

    localparam logic [CFG_IDX_W-1:0] REG_GEO0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GEO1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GEO2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GEO3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SIN   = 3'd6;

    localparam logic [15:0] PITCH_RST = 16'd10;
    localparam logic [15:0] COS_RST   = 16'd32487;
    localparam logic [15:0] SIN_RST   = 16'd4277;

    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_LAYER  = 2'd1;
    localparam logic [1:0] ERR_MODLEN = 2'd2;

    typedef struct packed {
        logic [9:0]         det_code;
        logic signed [17:0] entry_x;
        logic signed [17:0] entry_y;
        logic signed [17:0] entry_z;
        logic signed [17:0] exit_x;
        logic signed [17:0] exit_y;
        logic signed [17:0] exit_z;
    } t_item;

    typedef struct packed {
        logic                valid;
        logic                side;
        logic                bad;
        logic [1:0]          layer;
        logic [9:0]          det;
        logic [1:0]          err;
        logic [MODNUM_W-1:0] modnum;
        logic [15:0]         mlen;
        logic [5:0]          module_res;
        logic signed [17:0]  pz;
        logic [15:0]         rad;
        logic                neg;
        logic [LX_W-1:0]     lx;
    } t_tag;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cordic;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] den;
    } t_div;

    // atan(2^-i) in q28 radians, rounded to nearest
    function automatic logic signed [CW-1:0] atan_q28(input logic [STG_W-1:0] i);
        case (i)
            5'd0:    atan_q28 = 32'sd210828714;
            5'd1:    atan_q28 = 32'sd124459457;
            5'd2:    atan_q28 = 32'sd65760959;
            5'd3:    atan_q28 = 32'sd33381290;
            5'd4:    atan_q28 = 32'sd16755422;
            5'd5:    atan_q28 = 32'sd8385879;
            5'd6:    atan_q28 = 32'sd4193963;
            5'd7:    atan_q28 = 32'sd2097109;
            5'd8:    atan_q28 = 32'sd1048571;
            5'd9:    atan_q28 = 32'sd524287;
            5'd10:   atan_q28 = 32'sd262144;
            5'd11:   atan_q28 = 32'sd131072;
            5'd12:   atan_q28 = 32'sd65536;
            5'd13:   atan_q28 = 32'sd32768;
            5'd14:   atan_q28 = 32'sd16384;
            5'd15:   atan_q28 = 32'sd8192;
            5'd16:   atan_q28 = 32'sd4096;
            5'd17:   atan_q28 = 32'sd2048;
            5'd18:   atan_q28 = 32'sd1024;
            5'd19:   atan_q28 = 32'sd512;
            5'd20:   atan_q28 = 32'sd256;
            5'd21:   atan_q28 = 32'sd128;
            5'd22:   atan_q28 = 32'sd64;
            5'd23:   atan_q28 = 32'sd32;
            default: atan_q28 = 32'sd16;
        endcase
    endfunction

endpackage

[src/stereo_strip_hit_digitizer.sv]
// the entry-side result leaves first and the exit-side result of the same crossing follows it;
// a new crossing is taken while the exit side of the previous one is issued
// both sides share one row of cells, one side a cycle while the row is not held;
// the whole row holds while a result waits on the output
// synchronous active-low reset clears all valid flags and loads register defaults
module stereo_strip_hit_digitizer
    import ssh_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [GEO_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [9:0]           i_det_code,
    input  logic signed [17:0]   i_entry_x,
    input  logic signed [17:0]   i_entry_y,
    input  logic signed [17:0]   i_entry_z,
    input  logic signed [17:0]   i_exit_x,
    input  logic signed [17:0]   i_exit_y,
    input  logic signed [17:0]   i_exit_z,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [15:0]          o_hit_det_id,
    output logic                 o_side,
    output logic [1:0]           o_layer,
    output logic [5:0]           o_module_res,
    output logic [LX_W-1:0]      o_local_x,
    output logic [15:0]          o_strip,
    output logic [1:0]           o_error,
    output logic                 o_last
);

    logic [GEO_W-1:0] r_geo [4];
    logic [15:0]      r_pitch;
    logic [15:0]      r_cos;
    logic [15:0]      r_sin;

    logic  en;
    logic  accept;
    t_item r_item;
    logic  r_have;
    logic  r_side;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_geo[i] <= '0;
            end
            r_pitch <= PITCH_RST;
            r_cos   <= COS_RST;
            r_sin   <= SIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx) inside
                REG_GEO0, REG_GEO1, REG_GEO2, REG_GEO3: begin
                    r_geo[i_cfg_idx[1:0]] <= i_cfg_data;
                end
                REG_PITCH: r_pitch <= i_cfg_data[15:0];
                REG_COS:   r_cos   <= i_cfg_data[15:0];
                REG_SIN:   r_sin   <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // input holding stage and side sequencer
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = !r_have || (en && r_side);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_side <= 1'b0;
        end else begin
            if (accept) begin
                r_have <= 1'b1;
            end else if (en && r_have && r_side) begin
                r_have <= 1'b0;
            end
            if (en && r_have) begin
                r_side <= ~r_side;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= '{i_det_code, i_entry_x, i_entry_y, i_entry_z,
                        i_exit_x, i_exit_y, i_exit_z};
        end
    end

    // issue
    logic [8:0]           lay_p1;
    logic [GEO_W-1:0]     geo;
    logic signed [17:0]   px;
    logic signed [17:0]   py;
    logic signed [19:0]   vsum;
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    t_tag                 n_iss;
    t_cordic              n_c0;

    always_comb begin
        lay_p1       = r_item.det_code[9:1];
        n_iss        = '0;
        n_iss.valid  = r_have;
        n_iss.side   = r_side;
        n_iss.bad    = (lay_p1 == 9'd0) || (lay_p1 > 9'(NUM_LAYERS));
        n_iss.layer  = 2'(lay_p1 - 9'd1);
        n_iss.det    = r_item.det_code;
        geo          = r_geo[n_iss.layer];
        px           = r_side ? r_item.exit_x : r_item.entry_x;
        py           = r_side ? r_item.exit_y : r_item.entry_y;
        n_iss.pz     = r_side ? r_item.exit_z : r_item.entry_z;
        n_iss.rad    = r_side ? geo[31:16] : geo[15:0];
        n_iss.mlen   = geo[63:48];
        vsum         = 20'(r_item.entry_z) + $signed({4'b0, geo[47:32]});
        n_iss.modnum = (vsum > 20'sd0) ? vsum[MODNUM_W-1:0] : '0;
        if (n_iss.bad) begin
            n_iss.err = ERR_LAYER;
        end else if (n_iss.mlen == 16'd0) begin
            n_iss.err = ERR_MODLEN;
        end else begin
            n_iss.err = ERR_OK;
        end
        x0 = {{2{px[17]}}, px, 12'b0};
        y0 = {{2{py[17]}}, py, 12'b0};
        if (x0[CW-1]) begin
            n_c0.z = y0[CW-1] ? -PI_Q28 : PI_Q28;
            n_c0.x = -x0;
            n_c0.y = -y0;
        end else begin
            n_c0.z = '0;
            n_c0.x = x0;
            n_c0.y = y0;
        end
    end

    // cordic row
    t_tag    r_tc  [CORDIC_STAGES+1];
    t_cordic cst   [CORDIC_STAGES+1];
    t_cordic r_c0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc[0].valid <= 1'b0;
        end else if (en) begin
            r_tc[0] <= n_iss;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c0 <= n_c0;
        end
    end

    assign cst[0] = r_c0;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        ssh_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_stage (STG_W'(k)),
            .i_d     (cst[k]),
            .o_d     (cst[k+1])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tc[k+1].valid <= 1'b0;
            end else if (en) begin
                r_tc[k+1] <= r_tc[k];
            end
        end
    end

    // arc, circumference and stereo rotation
    t_tag               r_tm1, r_tm2, r_tm3;
    logic signed [48:0] r_arc_prod;
    logic [46:0]        r_circ_prod;
    logic signed [36:0] r_arc;
    logic [34:0]        r_circ;
    logic signed [53:0] r_arc_c;
    logic signed [34:0] r_zs;
    logic [DIV_W-1:0]   r_xmax;
    logic signed [48:0] arc_sum;
    logic [46:0]        circ_sum;

    assign arc_sum  = r_arc_prod + 49'sd2048;
    assign circ_sum = r_circ_prod + 47'd2048;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tm1.valid <= 1'b0;
            r_tm2.valid <= 1'b0;
            r_tm3.valid <= 1'b0;
        end else if (en) begin
            r_tm1 <= r_tc[CORDIC_STAGES];
            r_tm2 <= r_tm1;
            r_tm3 <= r_tm2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_arc_prod  <= $signed({1'b0, r_tc[CORDIC_STAGES].rad}) * cst[CORDIC_STAGES].z;
            r_circ_prod <= r_tc[CORDIC_STAGES].rad * TWO_PI_Q28;
            r_arc       <= arc_sum[48:12];
            r_circ      <= circ_sum[46:12];
            r_arc_c     <= r_arc * $signed({1'b0, r_cos});
            r_zs        <= r_tm2.pz * $signed({1'b0, r_sin});
            r_xmax      <= r_circ * r_cos;
        end
    end

    logic signed [54:0] zs_ext;
    logic signed [54:0] rot;
    logic [54:0]        rot_mag;
    t_tag               n_td0;
    t_div               n_d0;
    t_div               n_md0;

    always_comb begin
        zs_ext    = 55'(r_zs) <<< 16;
        rot       = r_tm3.side ? 55'(r_arc_c) + zs_ext : 55'(r_arc_c) - zs_ext;
        rot_mag   = rot[54] ? 55'(-rot) : 55'(rot);
        n_td0     = r_tm3;
        n_td0.neg = rot[54];
        n_d0.rem  = '0;
        n_d0.num  = rot_mag[DIV_W-1:0];
        n_d0.quo  = '0;
        n_d0.den  = r_xmax;
        n_md0.rem = '0;
        n_md0.num = {r_tm3.modnum, {(DIV_W-MODNUM_W){1'b0}}};
        n_md0.quo = '0;
        n_md0.den = DIV_W'(r_tm3.mlen);
    end

    // modulo row with the module division alongside
    t_tag r_td [DIV_W+1];
    t_tag n_td [DIV_W+1];
    t_div dst  [DIV_W+1];
    t_div mst  [MOD_STEPS+1];
    t_div r_d0;
    t_div r_md0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_td[0].valid <= 1'b0;
        end else if (en) begin
            r_td[0] <= n_td0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d0  <= n_d0;
            r_md0 <= n_md0;
        end
    end

    assign dst[0] = r_d0;
    assign mst[0] = r_md0;
    assign n_td[0] = r_td[0];

    for (genvar k = 0; k < MOD_STEPS; k++) begin : g_module
        ssh_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (mst[k]),
            .o_d   (mst[k+1])
        );
    end

    for (genvar k = 0; k < DIV_W; k++) begin : g_mod
        ssh_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (dst[k]),
            .o_d   (dst[k+1])
        );

        always_comb begin
            n_td[k+1] = r_td[k];
            if (k == MOD_STEPS) begin
                if (r_td[k].err == ERR_MODLEN) begin
                    n_td[k+1].module_res = '0;
                end else if (mst[MOD_STEPS].quo[MODNUM_W-1:0] > MODNUM_W'(63)) begin
                    n_td[k+1].module_res = 6'd63;
                end else begin
                    n_td[k+1].module_res = mst[MOD_STEPS].quo[5:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_td[k+1].valid <= 1'b0;
            end else if (en) begin
                r_td[k+1] <= n_td[k+1];
            end
        end
    end

    // floor the remainder, local x, strip division
    t_div             dfin;
    logic [DIV_W-1:0] rmod;
    t_tag             n_ts0;
    t_div             n_s0;

    always_comb begin
        dfin = dst[DIV_W];
        if (r_td[DIV_W].neg && dfin.rem != '0) begin
            rmod = dfin.den - dfin.rem;
        end else begin
            rmod = dfin.rem;
        end
        n_ts0    = r_td[DIV_W];
        n_ts0.lx = (dfin.den == '0) ? '0 : rmod[LX_SHIFT+LX_W-1:LX_SHIFT];
        n_s0.rem = '0;
        n_s0.num = {n_ts0.lx, {(DIV_W-LX_W){1'b0}}};
        n_s0.quo = '0;
        n_s0.den = DIV_W'(r_pitch);
    end

    t_tag r_ts [LX_W+1];
    t_div sst  [LX_W+1];
    t_div r_s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts[0].valid <= 1'b0;
        end else if (en) begin
            r_ts[0] <= n_ts0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0 <= n_s0;
        end
    end

    assign sst[0] = r_s0;

    for (genvar k = 0; k < LX_W; k++) begin : g_strip
        ssh_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (sst[k]),
            .o_d   (sst[k+1])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ts[k+1].valid <= 1'b0;
            end else if (en) begin
                r_ts[k+1] <= r_ts[k];
            end
        end
    end

    // output register
    t_tag            tl;
    logic [LX_W-1:0] sq;
    logic [15:0]     strip;
    logic [15:0]     det_id;
    logic            r_out_valid;
    logic [15:0]     r_hit_det_id;
    logic            r_side_o;
    logic [1:0]      r_layer;
    logic [5:0]      r_module_res;
    logic [LX_W-1:0] r_local_x;
    logic [15:0]     r_strip;
    logic [1:0]      r_error;

    always_comb begin
        tl = r_ts[LX_W];
        sq = sst[LX_W].quo[LX_W-1:0];
        if (r_pitch == 16'd0) begin
            strip = '0;
        end else if (sq > LX_W'(16'hFFFF)) begin
            strip = 16'hFFFF;
        end else begin
            strip = sq[15:0];
        end
        det_id = ({6'b0, tl.det} | {tl.module_res, 10'b0}) + 16'(tl.side);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= tl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side_o <= tl.side;
            r_error  <= tl.err;
            if (tl.bad) begin
                r_hit_det_id <= '0;
                r_layer      <= '0;
                r_module_res <= '0;
                r_local_x    <= '0;
                r_strip      <= '0;
            end else begin
                r_hit_det_id <= det_id;
                r_layer      <= tl.layer;
                r_module_res <= tl.module_res;
                r_local_x    <= tl.lx;
                r_strip      <= strip;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit_det_id = r_hit_det_id;
    assign o_side       = r_side_o;
    assign o_layer      = r_layer;
    assign o_module_res = r_module_res;
    assign o_local_x    = r_local_x;
    assign o_strip      = r_strip;
    assign o_error      = r_error;
    assign o_last       = r_side_o;

endmodule

[src/ssh_cordic_cell.sv]
module ssh_cordic_cell
    import ssh_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [STG_W-1:0] i_stage,
    input  t_cordic          i_d,
    output t_cordic          o_d
);

    t_cordic r_d;
    t_cordic n_d;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] a;

    always_comb begin
        xs = i_d.x >>> i_stage;
        ys = i_d.y >>> i_stage;
        a  = atan_q28(i_stage);
        if (!i_d.y[CW-1]) begin
            n_d.x = i_d.x + ys;
            n_d.y = i_d.y - xs;
            n_d.z = i_d.z + a;
        end else begin
            n_d.x = i_d.x - ys;
            n_d.y = i_d.y + xs;
            n_d.z = i_d.z - a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

[src/ssh_div_cell.sv]
module ssh_div_cell
    import ssh_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_div i_d,
    output t_div o_d
);

    t_div r_d;
    t_div n_d;
    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           ge;

    // one restoring step: one quotient bit
    always_comb begin
        trial   = {i_d.rem, i_d.num[DIV_W-1]};
        diff    = trial - {1'b0, i_d.den};
        ge      = trial >= {1'b0, i_d.den};
        n_d.rem = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        n_d.num = i_d.num << 1;
        n_d.quo = {i_d.quo[DIV_W-2:0], ge};
        n_d.den = i_d.den;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

[src/ssh_checker.sv]
module ssh_checker
    import ssh_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [15:0]          o_hit_det_id,
    input logic                 o_side,
    input logic [1:0]           o_layer,
    input logic [5:0]           o_module_res,
    input logic [LX_W-1:0]      o_local_x,
    input logic [15:0]          o_strip,
    input logic [1:0]           o_error,
    input logic                 o_last
);

    logic r_exp_last;

    // results leave in pairs, inner side first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_last <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            r_exp_last <= ~r_exp_last;
        end
    end

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_hit_det_id)
            && $stable(o_local_x) && $stable(o_strip))
        else $error("stalled transfer changed");

    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == r_exp_last) && (o_side == o_last))
        else $error("side order broken");

    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error == ERR_LAYER |-> o_hit_det_id == 16'd0
            && o_local_x == '0 && o_strip == 16'd0 && o_module_res == 6'd0
            && o_layer == 2'd0)
        else $error("bad layer result not cleared");

    a_modlen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error == ERR_MODLEN |-> o_module_res == 6'd0)
        else $error("module set with zero module length");

endmodule

bind stereo_strip_hit_digitizer ssh_checker u_ssh_checker (.*);
